@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/md5_pkg.sv @@
// Package with MD5 constants, tables and round helpers.
package md5_pkg;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } chain_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db; 6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8; 6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] r;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
                4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
                4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
                4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    // Index of the message word that a round reads.
    function automatic logic [3:0] word_index(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'(5 * i[3:0] + 1);
                2'd2: g = 4'(3 * i[3:0] + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction
endpackage

@@ hdl/md5_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/md5_core.sv @@
// Compression unit: one MD5 round per cycle on a shared adder path.
module md5_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  md5_pkg::chain_t       chain_in,
    output logic [5:0]            word_sel,
    input  logic [31:0]           word_data,
    output md5_pkg::chain_t       chain_out,
    output md5_pkg::core_ctl_t    ctl
);
    import md5_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD} state_t;

    state_t      state_reg;
    logic [5:0]  round_reg;
    logic        done_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] f_val, t_val, rot_val, b_next;
    logic [5:0]  rd_round;

    // The message word for round i is addressed in the cycle before round i.
    assign rd_round = (state_reg == S_RUN) ? round_reg + 6'd1 : 6'd0;
    assign word_sel = {word_index(rd_round), 2'b00}; // word address in words*4 units

    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val = a_reg + f_val + word_data + round_const(round_reg);
        rot_val = (t_val << rot_amount(round_reg)) | (t_val >> (6'd32 - 6'(rot_amount(round_reg))));
        b_next = b_reg + rot_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    round_reg <= '0;
                    if (start)
                    begin
                        a_reg <= chain_in.a;
                        b_reg <= chain_in.b;
                        c_reg <= chain_in.c;
                        d_reg <= chain_in.d;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    a_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= b_reg;
                    b_reg <= b_next;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    chain_out.a <= chain_in.a + a_reg;
                    chain_out.b <= chain_in.b + b_reg;
                    chain_out.c <= chain_in.c + c_reg;
                    chain_out.d <= chain_in.d + d_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != S_IDLE);
    assign ctl.done  = done_reg;

    `ASSERT_NEXT(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "done while busy")
    `ASSERT_IMPLIES(a_start_idle, clk, rst_n, start, state_reg == S_IDLE, "start while busy")
    `ASSERT_NEXT(a_last_round, clk, rst_n, state_reg == S_RUN && round_reg == 6'd63,
        state_reg == S_ADD, "round count slip")
endmodule

@@ hdl/md5_message_digest_top.sv @@
// Top level of the streaming MD5 hasher: byte loader, padding sequencer and core.
// A plain byte is accepted while idle; the 64th byte of a block starts a compression, during which no input is taken.
// A message end pads one byte per cycle (held while a filled block compresses) up to
// byte 56, then appends 8 length bytes and compresses before the digest appears.
// The round unit does one of 64 rounds per cycle, which sets the block cost.
// Reset (rst_n low) restores the initial chaining words and clears the count.
module md5_message_digest_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_first,
    output logic [63:0] digest_second
);
    import md5_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_LEN, S_COMP, S_OUT} state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] count_reg;
    logic [63:0] len_reg;
    logic        ending_reg;
    chain_t      chain_reg;
    state_t      after_reg;

    logic        we;
    logic [5:0]  waddr;
    logic [7:0]  wdata;
    logic [5:0]  word_sel;
    logic [5:0]  raddr;
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] word_data;
    logic        core_start;
    chain_t      core_out;
    core_ctl_t   ctl;

    // Four byte-lane RAMs so one 32-bit word is read at once from a single address.
    assign raddr = word_sel;
    md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram0 (.clk, .we(we && waddr[1:0] == 2'd0),
        .waddr(waddr[5:2]), .wdata, .raddr(raddr[5:2]), .rdata(b0));
    md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram1 (.clk, .we(we && waddr[1:0] == 2'd1),
        .waddr(waddr[5:2]), .wdata, .raddr(raddr[5:2]), .rdata(b1));
    md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram2 (.clk, .we(we && waddr[1:0] == 2'd2),
        .waddr(waddr[5:2]), .wdata, .raddr(raddr[5:2]), .rdata(b2));
    md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram3 (.clk, .we(we && waddr[1:0] == 2'd3),
        .waddr(waddr[5:2]), .wdata, .raddr(raddr[5:2]), .rdata(b3));
    assign word_data = {b3, b2, b1, b0};

    md5_core u_core (
        .clk, .rst_n, .start(core_start), .chain_in(chain_reg), .word_sel,
        .word_data, .chain_out(core_out), .ctl
    );

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign waddr = fill_reg;

    always_comb
    begin
        we = 1'b0;
        wdata = data_byte;
        case (state_reg)
            S_IDLE:
            begin
                we = in_valid && byte_present;
            end
            S_PAD:
            begin
                we = 1'b1;
                wdata = ending_reg ? PAD_BYTE : 8'h00;
            end
            S_LEN:
            begin
                we = 1'b1;
                wdata = len_reg[7:0];
            end
            default: we = 1'b0;
        endcase
    end

    assign core_start = we && (fill_reg == 6'd63);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            after_reg  <= S_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            ending_reg <= 1'b0;
            chain_reg  <= '{INIT_A, INIT_B, INIT_C, INIT_D};
        end
        else
        begin
            if (we)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        len_reg <= count_reg + (byte_present ? 64'd8 : 64'd0);
                        if (byte_present)
                        begin
                            count_reg <= count_reg + 64'd8;
                        end
                        ending_reg <= 1'b1;
                        if (core_start)
                        begin
                            state_reg <= S_COMP;
                            after_reg <= message_end ? S_PAD : S_IDLE;
                        end
                        else if (message_end)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    ending_reg <= 1'b0;
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= S_COMP;
                        after_reg <= S_PAD;
                    end
                    else if (fill_reg == LEN_POS - 6'd1)
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    len_reg <= {8'h00, len_reg[63:8]};
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= S_COMP;
                        after_reg <= S_OUT;
                    end
                end
                S_COMP:
                begin
                    if (ctl.done)
                    begin
                        chain_reg <= core_out;
                        state_reg <= after_reg;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                        chain_reg <= '{INIT_A, INIT_B, INIT_C, INIT_D};
                        count_reg <= '0;
                        fill_reg  <= '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    function automatic logic [31:0] bswap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    assign digest_first  = {bswap(chain_reg.a), bswap(chain_reg.b)};
    assign digest_second = {bswap(chain_reg.c), bswap(chain_reg.d)};

    `ASSERT_IMPLIES(a_out_not_busy, clk, rst_n, out_valid, !ctl.busy, "digest while compressing")
    `ASSERT_IMPLIES(a_len_at_56, clk, rst_n, state_reg == S_LEN, fill_reg >= LEN_POS,
        "length outside tail")
    `ASSERT_IMPLIES(a_comp_busy, clk, rst_n, core_start, !ctl.busy, "start while busy")
endmodule

@@ tb/sv/tb_md5_message_digest_top.sv @@
// Self-checking testbench for the streaming MD5 hasher.
module tb_md5_message_digest_top;
    timeunit 1ns;
    timeprecision 1ps;
    import md5_pkg::*;

    class digest_scoreboard;
        logic [7:0]  block_bytes [64];
        logic [31:0] chain [4];
        logic [63:0] bit_total;
        logic [5:0]  fill;
        logic [63:0] pending_first [$];
        logic [63:0] pending_second [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = INIT_A;
            chain[1] = INIT_B;
            chain[2] = INIT_C;
            chain[3] = INIT_D;
            bit_total = '0;
            fill = '0;
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, k;
            int g, phase, r;
            int rots [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int i = 0; i < 64; i++) begin
                phase = i / 16;
                case (phase)
                    0: begin f = (b & c) | (~b & d); g = i; end
                    1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                    2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
                endcase
                // Sines table: floor(abs(sin(i+1)) * 2^32).
                k = 32'(longint'($floor((($sin(i + 1.0) < 0) ? -$sin(i + 1.0) : $sin(i + 1.0))
                                        * 4294967296.0)));
                t = a + f + w[g] + k;
                r = rots[phase * 4 + i % 4];
                a = d; d = c; c = b;
                b = b + ((t << r) | (t >> (32 - r)));
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void push(logic [7:0] v);
            block_bytes[fill] = v;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress();
        endfunction

        function void note_request(logic [7:0] data, logic present, logic fin);
            logic [63:0] len, h0, h1;
            if (present) begin
                bit_total += 64'd8;
                push(data);
            end
            if (!fin)
                return;
            len = bit_total;
            push(PAD_BYTE);
            while (fill != LEN_POS)
                push(8'h00);
            for (int i = 0; i < 8; i++)
                push(len[8*i +: 8]);
            for (int i = 0; i < 8; i++)
                h0[63 - 8*i -: 8] = chain[i / 4][8 * (i % 4) +: 8];
            for (int i = 8; i < 16; i++)
                h1[63 - 8*(i-8) -: 8] = chain[i / 4][8 * (i % 4) +: 8];
            pending_first.push_back(h0);
            pending_second.push_back(h1);
            restart();
        endfunction

        function void check_digest(logic [63:0] got_first, logic [63:0] got_second);
            logic [63:0] e0, e1;
            if (pending_first.size() == 0) begin
                $error("unexpected digest %h %h", got_first, got_second);
                errors++;
                return;
            end
            e0 = pending_first.pop_front();
            e1 = pending_second.pop_front();
            if (got_first !== e0) begin
                $error("digest_first expected %h actual %h", e0, got_first);
                errors++;
            end
            if (got_second !== e1) begin
                $error("digest_second expected %h actual %h", e1, got_second);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_first.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_first;
    logic [63:0] digest_second;

    digest_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    longint cycle_count;

    md5_message_digest_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_first(digest_first), .digest_second(digest_second)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Results are sampled at the edge and then checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_digest(digest_first, digest_second);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one request and waits until it is accepted.
    task automatic send_request(logic [7:0] data, logic present, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        byte_present <= present;
        message_end <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(data, present, fin);
    endtask

    task automatic send_message(int len, bit with_last_byte);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom), 1'b1, (i == len - 1) && with_last_byte);
        if (!with_last_byte || len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(9))
                0: len = $urandom_range(200, 64);
                1, 2: len = $urandom_range(64, 55);
                default: len = $urandom_range(20);
            endcase
            if ($urandom_range(9) == 0)
            begin
                // Idle requests scattered in.
                send_request(8'($urandom), 1'b0, 1'b0);
                sent++;
            end
            send_message(len, $urandom_range(1));
            sent += len + 1;
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        message_end = 1'b0;
        out_ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, idle request, byte extremes, block boundaries.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'haa, 1'b1, 1'b1);
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b1);
        drain();

        // The receiver stalls while requests pile up behind it.
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_message($urandom_range(10), 1'b1);
        join
        drain();

        send_idle_pct = 33;
        recv_idle_pct = 83;
        random_phase(350);
        drain();
        send_idle_pct = 83;
        recv_idle_pct = 33;
        random_phase(250);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        drain();

        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
